>>> hdl/mbr_pkg.sv
`default_nettype none
package mbr_pkg;

  localparam int unsigned POS_W     = 9;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned PAYLOAD_W = 177;
  localparam int unsigned TDATA_W   = 184;

  localparam logic [POS_W-1:0]  TABLE_BASE = 9'h1BE;
  localparam logic [POS_W-1:0]  TABLE_END  = 9'h1FE;
  localparam logic [POS_W-1:0]  SIG_POS    = 9'd510;
  localparam logic [POS_W-1:0]  LAST_POS   = 9'd511;
  localparam logic [SIZE_W-1:0] SECTOR_SIZE_RESET = 17'd512;

  localparam logic [7:0] SIG_LOW         = 8'h55;
  localparam logic [7:0] SIG_HIGH        = 8'hAA;
  localparam logic [7:0] BOOT_FLAG       = 8'h80;
  localparam logic [7:0] TYPE_EMPTY      = 8'h00;
  localparam logic [7:0] TYPE_PROTECTIVE = 8'hEE;

  localparam logic [3:0] OFS_BOOT  = 4'd0;
  localparam logic [3:0] OFS_TYPE  = 4'd4;
  localparam logic [3:0] OFS_START = 4'd8;
  localparam logic [3:0] OFS_COUNT = 4'd12;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIG   = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SIZE = 2'd2;

  localparam logic KIND_PARTITION = 1'b0;
  localparam logic KIND_SUMMARY   = 1'b1;

  typedef enum logic [2:0] {
    ST_RECV,
    ST_SCAN,
    ST_MUL,
    ST_LOAD,
    ST_OUT,
    ST_FIN,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic count;
    logic mul_off;
    logic rec_load;
    logic sum_load;
  } cmd_t;

  typedef struct packed {
    logic last_byte;
    logic bad;
    logic skip;
    logic last_entry;
  } stat_t;

  // MSB first, so entry_index lands in the lowest bits of tdata
  typedef struct packed {
    logic [2:0]  partition_count;
    logic        protective_found;
    logic [1:0]  status;
    logic [47:0] size_bytes;
    logic [47:0] start_offset;
    logic [31:0] sector_count;
    logic [31:0] start_lba;
    logic        bootable;
    logic [7:0]  type_code;
    logic [1:0]  entry_index;
  } payload_t;

endpackage
`default_nettype wire

>>> hdl/mbr_ctrl.sv
`default_nettype none
module mbr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  input  wire logic           m_tready,
  input  wire mbr_pkg::stat_t stat,
  output logic                s_tready,
  output logic                m_tvalid,
  output mbr_pkg::cmd_t       cmd
);

  mbr_pkg::state_t state, state_next;
  logic            in_acc;

  assign in_acc = s_tvalid && (state == mbr_pkg::ST_RECV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbr_pkg::ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mbr_pkg::ST_RECV: begin
        if (in_acc && stat.last_byte) state_next = mbr_pkg::ST_SCAN;
      end
      mbr_pkg::ST_SCAN: begin
        if (stat.bad) begin
          state_next = mbr_pkg::ST_FIN;
        end else if (stat.skip) begin
          if (stat.last_entry) state_next = mbr_pkg::ST_FIN;
        end else begin
          state_next = mbr_pkg::ST_MUL;
        end
      end
      mbr_pkg::ST_MUL:  state_next = mbr_pkg::ST_LOAD;
      mbr_pkg::ST_LOAD: state_next = mbr_pkg::ST_OUT;
      mbr_pkg::ST_OUT: begin
        if (m_tready) begin
          state_next = stat.last_entry ? mbr_pkg::ST_FIN : mbr_pkg::ST_SCAN;
        end
      end
      mbr_pkg::ST_FIN: state_next = mbr_pkg::ST_SUM;
      mbr_pkg::ST_SUM: begin
        if (m_tready) state_next = mbr_pkg::ST_RECV;
      end
      default: state_next = mbr_pkg::ST_RECV;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    cmd          = '0;
    case (state)
      mbr_pkg::ST_RECV: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      mbr_pkg::ST_SCAN: begin
        // skip empty and protective entries without a record
        cmd.step = !stat.bad && stat.skip;
      end
      mbr_pkg::ST_MUL:  cmd.mul_off  = 1'b1;
      mbr_pkg::ST_LOAD: cmd.rec_load = 1'b1;
      mbr_pkg::ST_OUT: begin
        m_tvalid  = 1'b1;
        cmd.step  = m_tready;
        cmd.count = m_tready;
      end
      mbr_pkg::ST_FIN:  cmd.sum_load = 1'b1;
      mbr_pkg::ST_SUM:  m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/mbr_dp.sv
`default_nettype none
module mbr_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         sector_start,
  input  wire logic                         cfg_we,
  input  wire logic [mbr_pkg::SIZE_W-1:0]   cfg_data,
  input  wire mbr_pkg::cmd_t                cmd,
  output mbr_pkg::stat_t                    stat,
  output mbr_pkg::payload_t                 rec,
  output logic                              rec_kind,
  output logic                              rec_last
);

  logic [mbr_pkg::SIZE_W-1:0] sector_size;
  logic [mbr_pkg::POS_W-1:0]  byte_position;
  logic [mbr_pkg::POS_W-1:0]  pos;
  logic [mbr_pkg::POS_W-1:0]  rel;
  logic [1:0]                 wr_entry;
  logic [3:0]                 wr_ofs;
  logic                       in_table;
  logic [7:0]                 signature_low;
  logic [1:0]                 status_reg;
  logic [1:0]                 idx;
  logic [2:0]                 n;
  logic                       prot;
  logic [mbr_pkg::PROD_W-1:0] off_reg;

  logic [7:0]                 entry_type  [4];
  logic                       entry_boot  [4];
  logic [mbr_pkg::WORD_W-1:0] entry_start [4];
  logic [mbr_pkg::WORD_W-1:0] entry_count [4];

  logic [mbr_pkg::WORD_W-1:0] mul_a;
  logic [48:0]                prod;
  logic [7:0]                 cur_type;

  assign pos      = sector_start ? '0 : byte_position;
  assign in_table = (pos >= mbr_pkg::TABLE_BASE) && (pos < mbr_pkg::TABLE_END);
  assign rel      = pos - mbr_pkg::TABLE_BASE;
  assign wr_entry = rel[5:4];
  assign wr_ofs   = rel[3:0];

  assign cur_type = entry_type[idx];
  assign mul_a    = cmd.mul_off ? entry_start[idx] : entry_count[idx];
  assign prod     = 49'(mul_a) * 49'(sector_size);

  assign stat.last_byte  = (pos == mbr_pkg::LAST_POS);
  assign stat.bad        = (status_reg != mbr_pkg::STATUS_OK);
  assign stat.skip       = (cur_type == mbr_pkg::TYPE_EMPTY) ||
                           (cur_type == mbr_pkg::TYPE_PROTECTIVE);
  assign stat.last_entry = (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_size   <= mbr_pkg::SECTOR_SIZE_RESET;
      byte_position <= '0;
      signature_low <= '0;
      status_reg    <= mbr_pkg::STATUS_OK;
      idx           <= '0;
      n             <= '0;
      prot          <= 1'b0;
    end else begin
      if (cfg_we) sector_size <= cfg_data;
      if (cmd.capture) begin
        byte_position <= pos + 1'b1;
        if (pos == mbr_pkg::SIG_POS) signature_low <= data_byte;
        if (stat.last_byte) begin
          idx  <= '0;
          n    <= '0;
          prot <= 1'b0;
          // zero sector size wins over a bad signature
          if (sector_size == '0) begin
            status_reg <= mbr_pkg::STATUS_ZERO_SIZE;
          end else if ((signature_low != mbr_pkg::SIG_LOW) ||
                       (data_byte != mbr_pkg::SIG_HIGH)) begin
            status_reg <= mbr_pkg::STATUS_BAD_SIG;
          end else begin
            status_reg <= mbr_pkg::STATUS_OK;
          end
        end
      end
      if (cmd.step) begin
        idx <= idx + 1'b1;
        if (cur_type == mbr_pkg::TYPE_PROTECTIVE) prot <= 1'b1;
      end
      if (cmd.count) n <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && in_table) begin
      case (wr_ofs) inside
        mbr_pkg::OFS_BOOT:
          entry_boot[wr_entry] <= (data_byte == mbr_pkg::BOOT_FLAG);
        mbr_pkg::OFS_TYPE:
          entry_type[wr_entry] <= data_byte;
        [4'd8:4'd11]:
          entry_start[wr_entry][{wr_ofs[1:0], 3'b000} +: 8] <= data_byte;
        [4'd12:4'd15]:
          entry_count[wr_entry][{wr_ofs[1:0], 3'b000} +: 8] <= data_byte;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_off) off_reg <= prod[mbr_pkg::PROD_W-1:0];
    if (cmd.rec_load) begin
      rec.partition_count  <= '0;
      rec.protective_found <= 1'b0;
      rec.status           <= mbr_pkg::STATUS_OK;
      rec.size_bytes       <= prod[mbr_pkg::PROD_W-1:0];
      rec.start_offset     <= off_reg;
      rec.sector_count     <= entry_count[idx];
      rec.start_lba        <= entry_start[idx];
      rec.bootable         <= entry_boot[idx];
      rec.type_code        <= cur_type;
      rec.entry_index      <= n[1:0];
      rec_kind             <= mbr_pkg::KIND_PARTITION;
      rec_last             <= 1'b0;
    end else if (cmd.sum_load) begin
      rec.partition_count  <= n;
      rec.protective_found <= prot;
      rec.status           <= status_reg;
      rec.size_bytes       <= '0;
      rec.start_offset     <= '0;
      rec.sector_count     <= '0;
      rec.start_lba        <= '0;
      rec.bootable         <= 1'b0;
      rec.type_code        <= '0;
      rec.entry_index      <= '0;
      rec_kind             <= mbr_pkg::KIND_SUMMARY;
      rec_last             <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mbr_partition_table_parser.sv
`default_nettype none
// MBR partition table parser.
// Input stream (s_*): one sector byte per request, in address order; tuser
// marks byte 0 of a new sector and restarts the position count. After byte
// 511 the position wraps, so the next sector may also follow without a mark.
// Bytes are taken at one per cycle while the block is collecting.
// Once byte 511 is taken, input is held off while the records go out on m_*:
// with a good signature and a nonzero sector size, one partition record per
// entry that is neither empty nor protective, then a summary record with
// tlast high. Each entry is inspected in turn; a reported one then goes
// through the shared 32x17 multiplier (offset, then size) before its record
// is shown. The summary is loaded after the last entry, or after a bad
// signature or zero sector size with no partition record sent before it.
// A stalled receiver holds the current record and the scan until it is
// taken.
// cfg_* writes the sector size (reset 512); it is always ready and is to be
// written between sectors only.
// Reset (rst, synchronous) restores the sector size, clears the position
// and returns to collecting; captured table entries are not cleared.
module mbr_partition_table_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // data_byte
  input  wire logic                            s_tuser,   // sector_start
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // entry_index, type_code, bootable, start_lba, sector_count, start_offset,
  // size_bytes, status, protective_found, partition_count, zero fill
  output logic [mbr_pkg::TDATA_W-1:0]          m_tdata,
  output logic                                 m_tuser,   // record_kind
  output logic                                 m_tlast,   // last
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mbr_pkg::SIZE_W-1:0]      cfg_data
);

  mbr_pkg::cmd_t     cmd;
  mbr_pkg::stat_t    stat;
  mbr_pkg::payload_t rec;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(mbr_pkg::TDATA_W - mbr_pkg::PAYLOAD_W){1'b0}}, rec};

  mbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  mbr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (s_tdata),
    .sector_start (s_tuser),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .rec          (rec),
    .rec_kind     (m_tuser),
    .rec_last     (m_tlast)
  );

  // input and output never run at the same time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a record is pending");

  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser))
    else $error("tlast and record kind disagree");

  a_resume: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not resumed after summary");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[176:174] <= 3'd4))
    else $error("partition count out of range");

endmodule
`default_nettype wire
